// ----- rtl/time_bucket_averager_unit_assert.svh -----
// ----------------------------------------------------------------------------
// time bucket averager assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef TIME_BUCKET_AVERAGER_UNIT_ASSERT_SVH
`define TIME_BUCKET_AVERAGER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("time bucket averager check failed");

// next-cycle implication, sampled on clk, off during reset
`define TBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("time bucket averager check failed");

`endif

// ----- rtl/tba_pkg.sv -----
// ----------------------------------------------------------------------------
// tba_pkg
// shared constants and types of the time bucket averager
// ----------------------------------------------------------------------------
package tba_pkg;

  localparam int TBA_COUNT_BITS = 16;
  localparam int TBA_QUOT_W     = 14;
  localparam int TBA_FIFO_DEPTH = 4;

  localparam int TBA_TIME_W     = 31;
  localparam int TBA_TEMP_W     = 15;
  localparam int TBA_HUM_W      = 14;
  localparam int TBA_PRESS_W    = 17;
  localparam int TBA_STEP_W     = 20;

  localparam int TBA_AVG_TEMP_W  = 12;
  localparam int TBA_AVG_HUM_W   = 11;
  localparam int TBA_AVG_PRESS_W = 14;

  localparam int TBA_CFG_IDX_W  = 3;
  localparam int TBA_CFG_DATA_W = 31;

  localparam logic [TBA_CFG_IDX_W-1:0] TBA_CFG_USE_END   = 3'd0;
  localparam logic [TBA_CFG_IDX_W-1:0] TBA_CFG_WIN_START = 3'd1;
  localparam logic [TBA_CFG_IDX_W-1:0] TBA_CFG_WIN_END   = 3'd2;
  localparam logic [TBA_CFG_IDX_W-1:0] TBA_CFG_STEP      = 3'd3;
  localparam logic [TBA_CFG_IDX_W-1:0] TBA_CFG_PRESS_EN  = 3'd4;

  localparam logic [TBA_STEP_W-1:0] TBA_STEP_RESET = 20'd300;

  localparam logic TBA_REQ_SAMPLE = 1'b0;
  localparam logic TBA_REQ_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    TBA_ST_IDLE,
    TBA_ST_DIV,
    TBA_ST_DONE
  } tba_state_t;

endpackage

// ----- rtl/time_bucket_averager_unit.sv -----
// ----------------------------------------------------------------------------
// time_bucket_averager_unit
// time-bucketed boxcar averager and decimator for sensor samples
// ----------------------------------------------------------------------------
// The front takes one beat per clock while the record queue has room: it
// filters samples by the time window, accumulates the open bucket and,
// when a sample closes the bucket or a flush ends the stream, pushes the
// bucket totals into a four-entry queue. The back drains that queue through
// a shift-subtract divider that forms all three rounded means together, one
// quotient bit per cycle; each result passes from the queue head to the output
// register through a load, 14 divider steps and a hand-over. A burst of closing
// items stalls input only once the queue holds four results not yet divided.
// The output register lets the next division run while a result waits to be
// taken.
module time_bucket_averager_unit #(
  parameter int COUNT_BITS = tba_pkg::TBA_COUNT_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [tba_pkg::TBA_CFG_IDX_W-1:0]          cfg_index,
  input  logic [tba_pkg::TBA_CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_req_type,
  input  logic [tba_pkg::TBA_TIME_W-1:0]             in_sample_time,
  input  logic signed [tba_pkg::TBA_TEMP_W-1:0]      in_temperature,
  input  logic [tba_pkg::TBA_HUM_W-1:0]              in_humidity,
  input  logic [tba_pkg::TBA_PRESS_W-1:0]            in_pressure,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [tba_pkg::TBA_TIME_W-1:0]             out_bucket_time,
  output logic signed [tba_pkg::TBA_AVG_TEMP_W-1:0]  out_avg_temperature,
  output logic [tba_pkg::TBA_AVG_HUM_W-1:0]          out_avg_humidity,
  output logic [tba_pkg::TBA_AVG_PRESS_W-1:0]        out_avg_pressure,
  output logic [COUNT_BITS-1:0]                      out_bucket_count,
  output logic                                       out_count_saturated,
  output logic                                       out_from_flush
);

  import tba_pkg::*;

  localparam int TS_W  = COUNT_BITS + TBA_TEMP_W;
  localparam int HS_W  = COUNT_BITS + TBA_HUM_W;
  localparam int PS_W  = COUNT_BITS + TBA_PRESS_W;
  localparam int REC_W = TBA_TIME_W + TS_W + HS_W + PS_W + COUNT_BITS + 3;

  logic                   push_valid, push_ready, pop_valid, pop_ready;
  logic [REC_W-1:0]       push_data, pop_data;

  logic [TBA_TIME_W-1:0]  f_begin, b_begin;
  logic signed [TS_W-1:0] f_temp, b_temp;
  logic [HS_W-1:0]        f_hum, b_hum;
  logic [PS_W-1:0]        f_press, b_press;
  logic [COUNT_BITS-1:0]  f_count, b_count;
  logic                   f_sat, f_flush, f_pen, b_sat, b_flush, b_pen;

  tba_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_sample_time (in_sample_time),
    .in_temperature (in_temperature),
    .in_humidity    (in_humidity),
    .in_pressure    (in_pressure),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .rec_begin      (f_begin),
    .rec_temp       (f_temp),
    .rec_hum        (f_hum),
    .rec_press      (f_press),
    .rec_count      (f_count),
    .rec_sat        (f_sat),
    .rec_flush      (f_flush),
    .rec_press_en   (f_pen)
  );

  assign push_data = {f_begin, f_temp, f_hum, f_press, f_count, f_sat, f_flush, f_pen};

  tba_fifo #(.WIDTH(REC_W), .DEPTH(TBA_FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {b_begin, b_temp, b_hum, b_press, b_count, b_sat, b_flush, b_pen} = pop_data;

  tba_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .rec_begin           (b_begin),
    .rec_temp            (b_temp),
    .rec_hum             (b_hum),
    .rec_press           (b_press),
    .rec_count           (b_count),
    .rec_sat             (b_sat),
    .rec_flush           (b_flush),
    .rec_press_en        (b_pen),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bucket_time     (out_bucket_time),
    .out_avg_temperature (out_avg_temperature),
    .out_avg_humidity    (out_avg_humidity),
    .out_avg_pressure    (out_avg_pressure),
    .out_bucket_count    (out_bucket_count),
    .out_count_saturated (out_count_saturated),
    .out_from_flush      (out_from_flush)
  );

endmodule

// ----- rtl/tba_fifo.sv -----
// ----------------------------------------------------------------------------
// tba_fifo
// small register queue of closed bucket records between front and back
// ----------------------------------------------------------------------------
module tba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  always_comb begin
    push_ready = (fill_r != CNT_W'(DEPTH));
    pop_valid  = (fill_r != '0);
    pop_data   = mem_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/tba_front.sv -----
// ----------------------------------------------------------------------------
// tba_front
// configuration registers, window filter, bucket accumulation and closing
// ----------------------------------------------------------------------------
module tba_front #(
  parameter int COUNT_BITS = tba_pkg::TBA_COUNT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tba_pkg::TBA_CFG_IDX_W-1:0]     cfg_index,
  input  logic [tba_pkg::TBA_CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_req_type,
  input  logic [tba_pkg::TBA_TIME_W-1:0]        in_sample_time,
  input  logic signed [tba_pkg::TBA_TEMP_W-1:0] in_temperature,
  input  logic [tba_pkg::TBA_HUM_W-1:0]         in_humidity,
  input  logic [tba_pkg::TBA_PRESS_W-1:0]       in_pressure,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [tba_pkg::TBA_TIME_W-1:0]        rec_begin,
  output logic signed [COUNT_BITS+14:0]         rec_temp,
  output logic [COUNT_BITS+13:0]                rec_hum,
  output logic [COUNT_BITS+16:0]                rec_press,
  output logic [COUNT_BITS-1:0]                 rec_count,
  output logic                                  rec_sat,
  output logic                                  rec_flush,
  output logic                                  rec_press_en
);

  import tba_pkg::*;

  localparam int TS_W = COUNT_BITS + TBA_TEMP_W;
  localparam int HS_W = COUNT_BITS + TBA_HUM_W;
  localparam int PS_W = COUNT_BITS + TBA_PRESS_W;

  logic                   use_end_r;
  logic [TBA_TIME_W-1:0]  win_start_r;
  logic [TBA_TIME_W-1:0]  win_end_r;
  logic [TBA_STEP_W-1:0]  step_r;
  logic                   press_en_r;

  logic                   open_r, open_nxt;
  logic [TBA_TIME_W-1:0]  begin_r, begin_nxt;
  logic [COUNT_BITS-1:0]  total_r, total_nxt;
  logic signed [TS_W-1:0] tsum_r, tsum_nxt;
  logic [HS_W-1:0]        hsum_r, hsum_nxt;
  logic [PS_W-1:0]        psum_r, psum_nxt;
  logic                   sat_r, sat_nxt;

  logic                   accept, keep, close;
  logic [TBA_TIME_W-1:0]  begin_eff, elapsed;
  logic [COUNT_BITS-1:0]  base_total;
  logic signed [TS_W-1:0] base_tsum, temp_ext;
  logic [HS_W-1:0]        base_hsum;
  logic [PS_W-1:0]        base_psum;
  logic                   base_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_end_r   <= 1'b0;
      win_start_r <= '0;
      win_end_r   <= '1;
      step_r      <= TBA_STEP_RESET;
      press_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        TBA_CFG_USE_END:   use_end_r   <= cfg_wdata[0];
        TBA_CFG_WIN_START: win_start_r <= cfg_wdata[TBA_TIME_W-1:0];
        TBA_CFG_WIN_END:   win_end_r   <= cfg_wdata[TBA_TIME_W-1:0];
        TBA_CFG_STEP:      step_r      <= cfg_wdata[TBA_STEP_W-1:0];
        TBA_CFG_PRESS_EN:  press_en_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_ready  = push_ready;
    accept    = in_valid && in_ready;
    keep      = (in_sample_time >= win_start_r) &&
                (!use_end_r || (in_sample_time <= win_end_r));
    begin_eff = open_r ? begin_r : in_sample_time;
    elapsed   = in_sample_time - begin_eff;
    close     = keep && (in_sample_time >= begin_eff) &&
                (elapsed >= TBA_TIME_W'(step_r));

    base_total = close ? '0 : total_r;
    base_tsum  = close ? '0 : tsum_r;
    base_hsum  = close ? '0 : hsum_r;
    base_psum  = close ? '0 : psum_r;
    base_sat   = close ? 1'b0 : sat_r;
    temp_ext   = $signed({{COUNT_BITS{in_temperature[TBA_TEMP_W-1]}}, in_temperature});

    open_nxt  = open_r;
    begin_nxt = begin_r;
    total_nxt = total_r;
    tsum_nxt  = tsum_r;
    hsum_nxt  = hsum_r;
    psum_nxt  = psum_r;
    sat_nxt   = sat_r;

    if (accept) begin
      if (in_req_type == TBA_REQ_FLUSH) begin
        open_nxt  = 1'b0;
        begin_nxt = '0;
        total_nxt = '0;
        tsum_nxt  = '0;
        hsum_nxt  = '0;
        psum_nxt  = '0;
        sat_nxt   = 1'b0;
      end else if (keep) begin
        open_nxt  = 1'b1;
        begin_nxt = close ? in_sample_time : begin_eff;
        total_nxt = base_total;
        tsum_nxt  = base_tsum;
        hsum_nxt  = base_hsum;
        psum_nxt  = base_psum;
        sat_nxt   = base_sat;
        if (base_total == {COUNT_BITS{1'b1}}) begin
          sat_nxt = 1'b1;
        end else begin
          total_nxt = base_total + 1'b1;
          tsum_nxt  = base_tsum + temp_ext;
          hsum_nxt  = base_hsum + HS_W'(in_humidity);
          if (press_en_r) begin
            psum_nxt = base_psum + PS_W'(in_pressure);
          end
        end
      end
    end

    push_valid   = accept && ((in_req_type == TBA_REQ_FLUSH) ? open_r :
                              (close && (total_r != '0)));
    rec_begin    = begin_r;
    rec_temp     = tsum_r;
    rec_hum      = hsum_r;
    rec_press    = psum_r;
    rec_count    = total_r;
    rec_sat      = sat_r;
    rec_flush    = (in_req_type == TBA_REQ_FLUSH);
    rec_press_en = press_en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      begin_r <= '0;
      total_r <= '0;
      tsum_r  <= '0;
      hsum_r  <= '0;
      psum_r  <= '0;
      sat_r   <= 1'b0;
    end else begin
      open_r  <= open_nxt;
      begin_r <= begin_nxt;
      total_r <= total_nxt;
      tsum_r  <= tsum_nxt;
      hsum_r  <= hsum_nxt;
      psum_r  <= psum_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

// ----- rtl/tba_back.sv -----
// ----------------------------------------------------------------------------
// tba_back
// shift-subtract rounding divider for the three means and the output register
// ----------------------------------------------------------------------------
module tba_back #(
  parameter int COUNT_BITS = tba_pkg::TBA_COUNT_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       pop_valid,
  output logic                                       pop_ready,
  input  logic [tba_pkg::TBA_TIME_W-1:0]             rec_begin,
  input  logic signed [COUNT_BITS+14:0]              rec_temp,
  input  logic [COUNT_BITS+13:0]                     rec_hum,
  input  logic [COUNT_BITS+16:0]                     rec_press,
  input  logic [COUNT_BITS-1:0]                      rec_count,
  input  logic                                       rec_sat,
  input  logic                                       rec_flush,
  input  logic                                       rec_press_en,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [tba_pkg::TBA_TIME_W-1:0]             out_bucket_time,
  output logic signed [tba_pkg::TBA_AVG_TEMP_W-1:0]  out_avg_temperature,
  output logic [tba_pkg::TBA_AVG_HUM_W-1:0]          out_avg_humidity,
  output logic [tba_pkg::TBA_AVG_PRESS_W-1:0]        out_avg_pressure,
  output logic [COUNT_BITS-1:0]                      out_bucket_count,
  output logic                                       out_count_saturated,
  output logic                                       out_from_flush
);

  import tba_pkg::*;

  localparam int TS_W  = COUNT_BITS + TBA_TEMP_W;
  localparam int REM_W = COUNT_BITS + 18;
  localparam int QW    = TBA_QUOT_W;
  localparam int CNT_W = $clog2(QW);

  tba_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [REM_W-1:0]       trem_r, trem_nxt, hrem_r, hrem_nxt, prem_r, prem_nxt;
  logic [REM_W-1:0]       ds_r, ds_nxt;
  logic [QW-1:0]          tq_r, tq_nxt, hq_r, hq_nxt, pq_r, pq_nxt;
  logic                   tneg_r, tneg_nxt;
  logic [TBA_TIME_W-1:0]  begin_r, begin_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic                   sat_r, sat_nxt, flush_r, flush_nxt, pen_r, pen_nxt;

  logic                         ovalid_r, ovalid_nxt;
  logic [TBA_TIME_W-1:0]        otime_r, otime_nxt;
  logic [TBA_AVG_TEMP_W-1:0]    otemp_r, otemp_nxt;
  logic [TBA_AVG_HUM_W-1:0]     ohum_r, ohum_nxt;
  logic [TBA_AVG_PRESS_W-1:0]   opress_r, opress_nxt;
  logic [COUNT_BITS-1:0]        ocount_r, ocount_nxt;
  logic                         osat_r, osat_nxt, oflush_r, oflush_nxt;

  logic                   out_free, load, step_en, deliver;
  logic                   t_ge, h_ge, p_ge;
  logic [TS_W-1:0]        tmag;
  logic [REM_W-1:0]       five_n, ten_n;
  logic [QW-1:0]          tq_signed;

  always_comb begin
    out_free = !ovalid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TBA_ST_IDLE: begin
        if (pop_valid) state_nxt = TBA_ST_DIV;
      end
      TBA_ST_DIV: begin
        if (cnt_r == '0) state_nxt = TBA_ST_DONE;
      end
      TBA_ST_DONE: begin
        if (out_free) state_nxt = TBA_ST_IDLE;
      end
      default: state_nxt = TBA_ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    pop_ready = 1'b0;
    step_en   = 1'b0;
    deliver   = 1'b0;
    case (state_r)
      TBA_ST_IDLE: pop_ready = 1'b1;
      TBA_ST_DIV:  step_en   = 1'b1;
      TBA_ST_DONE: deliver   = out_free;
      default: begin
      end
    endcase
    load = pop_ready && pop_valid;
  end

  // datapath
  always_comb begin
    tmag   = rec_temp[TS_W-1] ? TS_W'(-rec_temp) : TS_W'(rec_temp);
    five_n = REM_W'({rec_count, 2'b00}) + REM_W'(rec_count);
    ten_n  = five_n << 1;

    t_ge = (trem_r >= ds_r);
    h_ge = (hrem_r >= ds_r);
    p_ge = (prem_r >= ds_r);

    cnt_nxt   = cnt_r;
    trem_nxt  = trem_r;
    hrem_nxt  = hrem_r;
    prem_nxt  = prem_r;
    ds_nxt    = ds_r;
    tq_nxt    = tq_r;
    hq_nxt    = hq_r;
    pq_nxt    = pq_r;
    tneg_nxt  = tneg_r;
    begin_nxt = begin_r;
    count_nxt = count_r;
    sat_nxt   = sat_r;
    flush_nxt = flush_r;
    pen_nxt   = pen_r;

    if (load) begin
      cnt_nxt   = CNT_W'(QW - 1);
      trem_nxt  = REM_W'(tmag) + five_n;
      hrem_nxt  = REM_W'(rec_hum) + five_n;
      prem_nxt  = REM_W'(rec_press) + five_n;
      ds_nxt    = ten_n << (QW - 1);
      tq_nxt    = '0;
      hq_nxt    = '0;
      pq_nxt    = '0;
      tneg_nxt  = rec_temp[TS_W-1];
      begin_nxt = rec_begin;
      count_nxt = rec_count;
      sat_nxt   = rec_sat;
      flush_nxt = rec_flush;
      pen_nxt   = rec_press_en;
    end else if (step_en) begin
      cnt_nxt  = cnt_r - 1'b1;
      trem_nxt = t_ge ? trem_r - ds_r : trem_r;
      hrem_nxt = h_ge ? hrem_r - ds_r : hrem_r;
      prem_nxt = p_ge ? prem_r - ds_r : prem_r;
      ds_nxt   = ds_r >> 1;
      tq_nxt   = {tq_r[QW-2:0], t_ge};
      hq_nxt   = {hq_r[QW-2:0], h_ge};
      pq_nxt   = {pq_r[QW-2:0], p_ge};
    end

    tq_signed  = tneg_r ? (~tq_r + 1'b1) : tq_r;

    ovalid_nxt = ovalid_r;
    otime_nxt  = otime_r;
    otemp_nxt  = otemp_r;
    ohum_nxt   = ohum_r;
    opress_nxt = opress_r;
    ocount_nxt = ocount_r;
    osat_nxt   = osat_r;
    oflush_nxt = oflush_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (deliver) begin
      ovalid_nxt = 1'b1;
      otime_nxt  = begin_r;
      otemp_nxt  = tq_signed[TBA_AVG_TEMP_W-1:0];
      ohum_nxt   = hq_r[TBA_AVG_HUM_W-1:0];
      opress_nxt = pen_r ? pq_r[TBA_AVG_PRESS_W-1:0] : '0;
      ocount_nxt = count_r;
      osat_nxt   = sat_r;
      oflush_nxt = flush_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= TBA_ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    trem_r   <= trem_nxt;
    hrem_r   <= hrem_nxt;
    prem_r   <= prem_nxt;
    ds_r     <= ds_nxt;
    tq_r     <= tq_nxt;
    hq_r     <= hq_nxt;
    pq_r     <= pq_nxt;
    tneg_r   <= tneg_nxt;
    begin_r  <= begin_nxt;
    count_r  <= count_nxt;
    sat_r    <= sat_nxt;
    flush_r  <= flush_nxt;
    pen_r    <= pen_nxt;
    otime_r  <= otime_nxt;
    otemp_r  <= otemp_nxt;
    ohum_r   <= ohum_nxt;
    opress_r <= opress_nxt;
    ocount_r <= ocount_nxt;
    osat_r   <= osat_nxt;
    oflush_r <= oflush_nxt;
  end

  always_comb begin
    out_valid           = ovalid_r;
    out_bucket_time     = otime_r;
    out_avg_temperature = otemp_r;
    out_avg_humidity    = ohum_r;
    out_avg_pressure    = opress_r;
    out_bucket_count    = ocount_r;
    out_count_saturated = osat_r;
    out_from_flush      = oflush_r;
  end

endmodule

// ----- rtl/tba_checker.sv -----
// ----------------------------------------------------------------------------
// tba_checker
// port-level checks of the time bucket averager, bound to the top level
// ----------------------------------------------------------------------------
`include "time_bucket_averager_unit_assert.svh"

module tba_checker #(
  parameter int COUNT_BITS = tba_pkg::TBA_COUNT_BITS
) (
  input logic                                       clk,
  input logic                                       rst_n,
  input logic                                       out_valid,
  input logic                                       out_ready,
  input logic [tba_pkg::TBA_TIME_W-1:0]             out_bucket_time,
  input logic signed [tba_pkg::TBA_AVG_TEMP_W-1:0]  out_avg_temperature,
  input logic [tba_pkg::TBA_AVG_HUM_W-1:0]          out_avg_humidity,
  input logic [tba_pkg::TBA_AVG_PRESS_W-1:0]        out_avg_pressure,
  input logic [COUNT_BITS-1:0]                      out_bucket_count,
  input logic                                       out_count_saturated,
  input logic                                       out_from_flush
);

  import tba_pkg::*;

  localparam int PAY_W = TBA_TIME_W + TBA_AVG_TEMP_W + TBA_AVG_HUM_W + TBA_AVG_PRESS_W +
                         COUNT_BITS + 2;

  logic [PAY_W-1:0] out_payload;
  logic             temp_in_range;

  always_comb begin
    out_payload   = {out_bucket_time, out_avg_temperature, out_avg_humidity,
                     out_avg_pressure, out_bucket_count, out_count_saturated,
                     out_from_flush};
    temp_in_range = (out_avg_temperature >= -12'sd1639) &&
                    (out_avg_temperature <= 12'sd1639);
  end

  // a stalled result beat holds
  `TBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // every emitted bucket averaged at least one sample
  `TBA_ASSERT_NOW(a_count_nonzero, out_valid, out_bucket_count != '0)

  // rounded means stay inside the range of a single sample
  `TBA_ASSERT_NOW(a_hum_range, out_valid, out_avg_humidity <= 11'd1639)
  `TBA_ASSERT_NOW(a_temp_range, out_valid, temp_in_range)

endmodule

bind time_bucket_averager_unit tba_checker #(.COUNT_BITS(COUNT_BITS)) u_tba_checker (.*);
